### rtl/transparent_exchange_response_parser_defines.svh
// assertion macros for the transparent exchange response parser
// no dependencies; taken in by files that carry concurrent assertions
`ifndef TRANSPARENT_EXCHANGE_RESPONSE_PARSER_DEFINES_SVH
`define TRANSPARENT_EXCHANGE_RESPONSE_PARSER_DEFINES_SVH

// checked on every rising edge, off while reset is held
`define TERP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define TERP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/terp_pkg.sv
// types, codes and the status word classifier for the response parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package terp_pkg;

    // tags and length bytes
    localparam logic [7:0] TAG_ERR_STATUS = 8'hC0;
    localparam logic [7:0] TAG_FRAMING    = 8'h92;
    localparam logic [7:0] TAG_STATUS     = 8'h96;
    localparam logic [7:0] TAG_DATA       = 8'h97;
    localparam logic [7:0] TAG_RESULT     = 8'h90;
    localparam logic [7:0] LEN_ERR_STATUS = 8'h03;
    localparam logic [7:0] LEN_FRAMING    = 8'h01;
    localparam logic [7:0] LEN_STATUS     = 8'h02;
    localparam logic [7:0] RESULT_TRAILER = 8'h00;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;

    // status word classes
    localparam logic [3:0] CLS_9000  = 4'd0;
    localparam logic [3:0] CLS_6282  = 4'd1;
    localparam logic [3:0] CLS_6300  = 4'd2;
    localparam logic [3:0] CLS_6301  = 4'd3;
    localparam logic [3:0] CLS_6A81  = 4'd4;
    localparam logic [3:0] CLS_6700  = 4'd5;
    localparam logic [3:0] CLS_6A80  = 4'd6;
    localparam logic [3:0] CLS_6400  = 4'd7;
    localparam logic [3:0] CLS_6401  = 4'd8;
    localparam logic [3:0] CLS_6F00  = 4'd9;
    localparam logic [3:0] CLS_OTHER = 4'd10;

    typedef enum logic [3:0] {
        PH_TAG     = 4'd0,
        PH_ES_LEN  = 4'd1,
        PH_ES_CODE = 4'd2,
        PH_ES_SW1  = 4'd3,
        PH_ES_SW2  = 4'd4,
        PH_FR_LEN  = 4'd5,
        PH_FR_VAL  = 4'd6,
        PH_ST_LEN  = 4'd7,
        PH_ST_V1   = 4'd8,
        PH_ST_V2   = 4'd9,
        PH_DA_LEN  = 4'd10,
        PH_DA_PAY  = 4'd11,
        PH_RES_00  = 4'd12,
        PH_DISCARD = 4'd13
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [23:0] error_code;
        logic [3:0]  error_class;
        logic [7:0]  bit_framing;
        logic        crc_ok;
        logic        collision_ok;
        logic        parity_ok;
        logic        framing_ok;
        logic [7:0]  collision_pos;
        logic [2:0]  objects_seen;
    } t_result;

    function automatic logic [3:0] class_of(input logic [15:0] sw);
        logic [3:0] cls;
        unique case (sw)
            16'h9000: cls = CLS_9000;
            16'h6282: cls = CLS_6282;
            16'h6300: cls = CLS_6300;
            16'h6301: cls = CLS_6301;
            16'h6A81: cls = CLS_6A81;
            16'h6700: cls = CLS_6700;
            16'h6A80: cls = CLS_6A80;
            16'h6400: cls = CLS_6400;
            16'h6401: cls = CLS_6401;
            16'h6F00: cls = CLS_6F00;
            default:  cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

### rtl/transparent_exchange_response_parser.sv
// top level of the transparent exchange response parser
// depends on terp_pkg and transparent_exchange_response_parser_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "transparent_exchange_response_parser_defines.svh"

// Parses a reader's transparent exchange response one byte per request. Each
// accepted byte steps a small tag/length state machine in the same cycle and
// its results land in a two-entry output queue, so a result appears on the
// output in the cycle after its byte is taken. Sustained rate is one byte
// per cycle while unstalled; a byte that raises two results (a last payload
// byte followed by the completion or failure result) holds the input stalled
// while the queue drains, since the queue must have room for two results
// before a byte is taken. Output stall backs up through the queue straight
// into o_in_stall. Gathered fields are cleared whenever a response ends.
module transparent_exchange_response_parser
    import terp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last,
    // result request channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [23:0]      o_error_code,
    output logic [3:0]       o_error_class,
    output logic [7:0]       o_bit_framing,
    output logic             o_crc_ok,
    output logic             o_collision_ok,
    output logic             o_parity_ok,
    output logic             o_framing_ok,
    output logic [7:0]       o_collision_pos,
    output logic [2:0]       o_objects_seen
);

    // parser state
    t_phase      r_phase,     n_phase;
    logic [7:0]  r_left,      n_left;
    logic [7:0]  r_code,      n_code;
    logic [7:0]  r_sw1,       n_sw1;
    logic [23:0] r_err,       n_err;
    logic [3:0]  r_cls,       n_cls;
    logic [7:0]  r_frm,       n_frm;
    logic [3:0]  r_flags,     n_flags;
    logic [7:0]  r_coll,      n_coll;
    logic [2:0]  r_seen,      n_seen;

    // output queue, entry 0 is the head
    t_result     r_q0, n_q0;
    t_result     r_q1, n_q1;
    logic [1:0]  r_cnt, n_cnt;

    logic        out_pop;
    logic [1:0]  cnt_left;
    logic        in_take;

    // results raised by the byte on the input
    t_result     res0, res1;
    logic [1:0]  res_n;
    logic        fail;
    logic        discard;
    logic        payload;
    logic [15:0] sw_word;

    assign out_pop    = (r_cnt != 2'd0) && !i_out_stall;
    assign cnt_left   = r_cnt - {1'b0, out_pop};
    // only take a byte when both queue slots are free after this cycle's pop
    assign o_in_stall = (cnt_left != 2'd0);
    assign in_take    = i_in_valid && !o_in_stall;
    assign sw_word    = {r_sw1, i_in_byte};

    // parser step and result assembly
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_code  = r_code;
        n_sw1   = r_sw1;
        n_err   = r_err;
        n_cls   = r_cls;
        n_frm   = r_frm;
        n_flags = r_flags;
        n_coll  = r_coll;
        n_seen  = r_seen;
        fail    = 1'b0;
        discard = 1'b0;
        payload = 1'b0;

        unique case (r_phase)
            PH_TAG: begin
                case (i_in_byte)
                    TAG_ERR_STATUS: n_phase = PH_ES_LEN;
                    TAG_FRAMING:    n_phase = PH_FR_LEN;
                    TAG_STATUS:     n_phase = PH_ST_LEN;
                    TAG_DATA:       n_phase = PH_DA_LEN;
                    TAG_RESULT:     n_phase = PH_RES_00;
                    default:        fail    = 1'b1;
                endcase
            end
            PH_ES_LEN: begin
                if (i_in_byte == LEN_ERR_STATUS) n_phase = PH_ES_CODE;
                else fail = 1'b1;
            end
            PH_ES_CODE: begin
                n_code  = i_in_byte;
                n_phase = PH_ES_SW1;
            end
            PH_ES_SW1: begin
                n_sw1   = i_in_byte;
                n_phase = PH_ES_SW2;
            end
            PH_ES_SW2: begin
                n_err   = {r_code, sw_word};
                n_cls   = class_of(sw_word);
                n_seen  = r_seen | 3'b001;
                n_phase = PH_TAG;
            end
            PH_FR_LEN: begin
                if (i_in_byte == LEN_FRAMING) n_phase = PH_FR_VAL;
                else fail = 1'b1;
            end
            PH_FR_VAL: begin
                n_frm   = i_in_byte;
                n_seen  = r_seen | 3'b010;
                n_phase = PH_TAG;
            end
            PH_ST_LEN: begin
                if (i_in_byte == LEN_STATUS) n_phase = PH_ST_V1;
                else fail = 1'b1;
            end
            PH_ST_V1: begin
                n_flags = i_in_byte[3:0];
                n_phase = PH_ST_V2;
            end
            PH_ST_V2: begin
                n_coll  = i_in_byte;
                n_seen  = r_seen | 3'b100;
                n_phase = PH_TAG;
            end
            PH_DA_LEN: begin
                n_left  = i_in_byte;
                n_phase = (i_in_byte == 8'd0) ? PH_TAG : PH_DA_PAY;
            end
            PH_DA_PAY: begin
                payload = 1'b1;
                n_left  = r_left - 8'd1;
                if (r_left == 8'd1) n_phase = PH_TAG;
            end
            PH_RES_00: begin
                if (i_in_byte == RESULT_TRAILER) n_phase = PH_TAG;
                else fail = 1'b1;
            end
            default: begin
                // rest of a failed response, silent through its last byte as well
                discard = 1'b1;
            end
        endcase

        // failure result template, also used for the payload result
        res0       = '0;
        res0.kind  = KIND_FAIL;
        res1       = '0;
        res1.kind  = KIND_FAIL;
        res_n      = 2'd0;

        if (discard) begin
            res_n = 2'd0;
        end else if (fail) begin
            res_n = 2'd1;
            if (!i_last) n_phase = PH_DISCARD;
        end else begin
            // completion carries the fields as they stand after this byte
            if (i_last && n_phase == PH_TAG) begin
                res1.kind          = KIND_DONE;
                res1.error_code    = n_err;
                res1.error_class   = n_cls;
                res1.bit_framing   = n_frm;
                res1.crc_ok        = !n_flags[0];
                res1.collision_ok  = !n_flags[1];
                res1.parity_ok     = !n_flags[2];
                res1.framing_ok    = !n_flags[3];
                res1.collision_pos = n_coll;
                res1.objects_seen  = n_seen;
            end
            if (payload) begin
                res0.kind      = KIND_PAYLOAD;
                res0.data_byte = i_in_byte;
                res_n          = i_last ? 2'd2 : 2'd1;
            end else begin
                res0  = res1;
                res_n = i_last ? 2'd1 : 2'd0;
            end
        end

        // end of response: every reply starts from cleared fields
        if (i_last) begin
            n_phase = PH_TAG;
            n_left  = '0;
            n_code  = '0;
            n_sw1   = '0;
            n_err   = '0;
            n_cls   = '0;
            n_frm   = '0;
            n_flags = '0;
            n_coll  = '0;
            n_seen  = '0;
        end
    end

    // output queue next state
    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = cnt_left;
        if (in_take) begin
            // queue is empty after the pop here
            n_q0  = res0;
            n_q1  = res1;
            n_cnt = res_n;
        end else if (out_pop) begin
            n_q0 = r_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_left  <= '0;
            r_code  <= '0;
            r_sw1   <= '0;
            r_err   <= '0;
            r_cls   <= '0;
            r_frm   <= '0;
            r_flags <= '0;
            r_coll  <= '0;
            r_seen  <= '0;
            r_cnt   <= '0;
        end else begin
            if (in_take) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_code  <= n_code;
                r_sw1   <= n_sw1;
                r_err   <= n_err;
                r_cls   <= n_cls;
                r_frm   <= n_frm;
                r_flags <= n_flags;
                r_coll  <= n_coll;
                r_seen  <= n_seen;
            end
            r_cnt <= n_cnt;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out_valid     = (r_cnt != 2'd0);
    assign o_kind          = r_q0.kind;
    assign o_data_byte     = r_q0.data_byte;
    assign o_error_code    = r_q0.error_code;
    assign o_error_class   = r_q0.error_class;
    assign o_bit_framing   = r_q0.bit_framing;
    assign o_crc_ok        = r_q0.crc_ok;
    assign o_collision_ok  = r_q0.collision_ok;
    assign o_parity_ok     = r_q0.parity_ok;
    assign o_framing_ok    = r_q0.framing_ok;
    assign o_collision_pos = r_q0.collision_pos;
    assign o_objects_seen  = r_q0.objects_seen;

    // queue never holds more than two results
    `TERP_ASSERT_ALWAYS(a_cnt_bound, i_clk, !i_rst_n || r_cnt != 2'd3, "queue overfilled")
    // the second slot only ever holds a completion or a failure
    `TERP_ASSERT(a_second_not_payload, i_clk, i_rst_n,
        r_cnt == 2'd2 |-> r_q1.kind != KIND_PAYLOAD, "payload in second slot")
    // bytes of a failed response raise nothing
    `TERP_ASSERT(a_discard_silent, i_clk, i_rst_n,
        in_take && r_phase == PH_DISCARD |=> r_cnt == 2'd0, "result from discarded byte")
    // a last byte leaves the parser cleared
    `TERP_ASSERT(a_last_clears, i_clk, i_rst_n,
        in_take && i_last |=> r_phase == PH_TAG && r_seen == 3'd0 && r_left == 8'd0,
        "state not cleared at end of response")
    // a failure mid response moves into discard
    `TERP_ASSERT(a_fail_discard, i_clk, i_rst_n,
        in_take && fail && !i_last |=> r_phase == PH_DISCARD, "failure did not discard")

endmodule

`default_nettype wire

### tb/tb_transparent_exchange_response_parser.sv
// testbench for the transparent exchange response parser: directed responses, then random ones
// checks every result request against a predictor of the parser; depends on terp_pkg
`timescale 1ns / 1ps

module tb_transparent_exchange_response_parser;
    import terp_pkg::*;

    // run lengths and limits
    localparam int N_DIRECTED     = 30;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int LONG_HOLD      = 150;   // receiver hold-off, long enough to back up the input
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving on either side
    localparam int DRAIN_CYCLES   = 16;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    // byte side
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte  = 8'h00;
    logic        i_last     = 1'b0;

    // result side
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [23:0] o_error_code;
    logic [3:0]  o_error_class;
    logic [7:0]  o_bit_framing;
    logic        o_crc_ok;
    logic        o_collision_ok;
    logic        o_parity_ok;
    logic        o_framing_ok;
    logic [7:0]  o_collision_pos;
    logic [2:0]  o_objects_seen;

    transparent_exchange_response_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_error_code    (o_error_code),
        .o_error_class   (o_error_class),
        .o_bit_framing   (o_bit_framing),
        .o_crc_ok        (o_crc_ok),
        .o_collision_ok  (o_collision_ok),
        .o_parity_ok     (o_parity_ok),
        .o_framing_ok    (o_framing_ok),
        .o_collision_pos (o_collision_pos),
        .o_objects_seen  (o_objects_seen)
    );

    // results the parser still owes us, oldest first
    t_result pending_results [$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;

    // appends one expected result at the tail
    function automatic void queue_result(input t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // predictor: its own copy of the parser state
    // ------------------------------------------------------------------
    t_phase      rx_phase;
    logic [7:0]  rx_left;
    logic [7:0]  rx_code;
    logic [7:0]  rx_sw1;
    logic [23:0] rx_err;
    logic [3:0]  rx_cls;
    logic [7:0]  rx_framing;
    logic [3:0]  rx_flags;
    logic [7:0]  rx_collision;
    logic [2:0]  rx_seen;

    function automatic logic [3:0] status_word_class(input logic [15:0] sw);
        case (sw)
            16'h9000: return CLS_9000;
            16'h6282: return CLS_6282;
            16'h6300: return CLS_6300;
            16'h6301: return CLS_6301;
            16'h6A81: return CLS_6A81;
            16'h6700: return CLS_6700;
            16'h6A80: return CLS_6A80;
            16'h6400: return CLS_6400;
            16'h6401: return CLS_6401;
            16'h6F00: return CLS_6F00;
            default:  return CLS_OTHER;
        endcase
    endfunction

    // everything gathered goes back to zero whenever a response ends
    function automatic void clear_response();
        rx_phase     = PH_TAG;
        rx_left      = 8'h00;
        rx_code      = 8'h00;
        rx_sw1       = 8'h00;
        rx_err       = 24'h0;
        rx_cls       = 4'h0;
        rx_framing   = 8'h00;
        rx_flags     = 4'h0;
        rx_collision = 8'h00;
        rx_seen      = 3'h0;
    endfunction

    // steps the predictor by one accepted byte and queues the results it raises
    task automatic predict_response_byte(input logic [7:0] val, input logic lst);
        t_result    res;
        logic       broken;
        logic [15:0] sw;
        broken = 1'b0;
        // rest of a failed response: silent, the last byte just resets
        if (rx_phase == PH_DISCARD) begin
            if (lst) clear_response();
            return;
        end
        case (rx_phase)
            PH_TAG: begin
                if (val == TAG_ERR_STATUS)   rx_phase = PH_ES_LEN;
                else if (val == TAG_FRAMING) rx_phase = PH_FR_LEN;
                else if (val == TAG_STATUS)  rx_phase = PH_ST_LEN;
                else if (val == TAG_DATA)    rx_phase = PH_DA_LEN;
                else if (val == TAG_RESULT)  rx_phase = PH_RES_00;
                else                         broken = 1'b1;
            end
            PH_ES_LEN: begin
                if (val == LEN_ERR_STATUS) rx_phase = PH_ES_CODE;
                else                       broken = 1'b1;
            end
            PH_ES_CODE: begin
                rx_code  = val;
                rx_phase = PH_ES_SW1;
            end
            PH_ES_SW1: begin
                rx_sw1   = val;
                rx_phase = PH_ES_SW2;
            end
            PH_ES_SW2: begin
                sw       = {rx_sw1, val};
                rx_err   = {rx_code, sw};
                rx_cls   = status_word_class(sw);
                rx_seen  = rx_seen | 3'b001;
                rx_phase = PH_TAG;
            end
            PH_FR_LEN: begin
                if (val == LEN_FRAMING) rx_phase = PH_FR_VAL;
                else                    broken = 1'b1;
            end
            PH_FR_VAL: begin
                rx_framing = val;
                rx_seen    = rx_seen | 3'b010;
                rx_phase   = PH_TAG;
            end
            PH_ST_LEN: begin
                if (val == LEN_STATUS) rx_phase = PH_ST_V1;
                else                   broken = 1'b1;
            end
            PH_ST_V1: begin
                // flags are kept before the object completes
                rx_flags = val[3:0];
                rx_phase = PH_ST_V2;
            end
            PH_ST_V2: begin
                rx_collision = val;
                rx_seen      = rx_seen | 3'b100;
                rx_phase     = PH_TAG;
            end
            PH_DA_LEN: begin
                rx_left  = val;
                rx_phase = (val == 8'h00) ? PH_TAG : PH_DA_PAY;
            end
            PH_DA_PAY: begin
                res           = '0;
                res.kind      = KIND_PAYLOAD;
                res.data_byte = val;
                queue_result(res);
                rx_left = rx_left - 8'd1;
                if (rx_left == 8'h00) rx_phase = PH_TAG;
            end
            PH_RES_00: begin
                if (val == RESULT_TRAILER) rx_phase = PH_TAG;
                else                       broken = 1'b1;
            end
            default: broken = 1'b1;
        endcase

        if (broken) begin
            res      = '0;
            res.kind = KIND_FAIL;
            queue_result(res);
            if (lst) clear_response();
            else     rx_phase = PH_DISCARD;
        end else if (lst) begin
            res = '0;
            if (rx_phase == PH_TAG) begin
                res.kind          = KIND_DONE;
                res.error_code    = rx_err;
                res.error_class   = rx_cls;
                res.bit_framing   = rx_framing;
                res.crc_ok        = ~rx_flags[0];
                res.collision_ok  = ~rx_flags[1];
                res.parity_ok     = ~rx_flags[2];
                res.framing_ok    = ~rx_flags[3];
                res.collision_pos = rx_collision;
                res.objects_seen  = rx_seen;
            end else begin
                // response ended inside an object
                res.kind = KIND_FAIL;
            end
            queue_result(res);
            clear_response();
        end
    endtask

    initial clear_response();

    // ------------------------------------------------------------------
    // byte sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_byte(input logic [7:0] val, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            // a third of the bursts follow on with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_in_valid <= 1'b1;
        i_in_byte  <= val;
        i_last     <= lst;
        // request taken at the first edge that sees no stall
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_response_byte(val, lst);
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // result receiver: its own stall pattern, plus a long hold-off on demand
    // ------------------------------------------------------------------
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int mode_left = 0;
    int rx_mode   = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left = mode_left - 1;
            case (rx_mode)
                0:       i_out_stall <= 1'b0;                          // free running
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);   // light back-pressure
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);   // heavy back-pressure
                default: i_out_stall <= ~i_out_stall;                  // alternating stall
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker and watchdog
    // ------------------------------------------------------------------
    t_result     got_res;
    t_result     want_res;
    int unsigned idle_cycles = 0;

    task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result(input t_result want, input t_result got);
        check_field("kind",          24'(want.kind),          24'(got.kind));
        check_field("data_byte",     24'(want.data_byte),     24'(got.data_byte));
        check_field("error_code",    want.error_code,         got.error_code);
        check_field("error_class",   24'(want.error_class),   24'(got.error_class));
        check_field("bit_framing",   24'(want.bit_framing),   24'(got.bit_framing));
        check_field("crc_ok",        24'(want.crc_ok),        24'(got.crc_ok));
        check_field("collision_ok",  24'(want.collision_ok),  24'(got.collision_ok));
        check_field("parity_ok",     24'(want.parity_ok),     24'(got.parity_ok));
        check_field("framing_ok",    24'(want.framing_ok),    24'(got.framing_ok));
        check_field("collision_pos", 24'(want.collision_pos), 24'(got.collision_pos));
        check_field("objects_seen",  24'(want.objects_seen),  24'(got.objects_seen));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got_res.kind          = o_kind;
                got_res.data_byte     = o_data_byte;
                got_res.error_code    = o_error_code;
                got_res.error_class   = o_error_class;
                got_res.bit_framing   = o_bit_framing;
                got_res.crc_ok        = o_crc_ok;
                got_res.collision_ok  = o_collision_ok;
                got_res.parity_ok     = o_parity_ok;
                got_res.framing_ok    = o_framing_ok;
                got_res.collision_pos = o_collision_pos;
                got_res.objects_seen  = o_objects_seen;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                             $time, o_kind, o_data_byte);
                    mismatches++;
                end else begin
                    want_res = pending_results.pop_front();
                    compare_result(want_res, got_res);
                end
            end
            // no request moving on either side for too long means a hang
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // directed responses
    // expected result typed in where it is obvious, the rest goes to the predictor
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]  val;
        logic        lst;
        logic        typed;   // final result of this byte is typed in below
        logic [1:0]  kind;
        logic [23:0] code;
        logic [3:0]  cls;
        logic [2:0]  seen;
    } stim_row_t;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // bare result marker straight after reset: completion with nothing gathered
        '{8'h90, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h00, 1'b1, 1'b1, KIND_DONE,    24'h0,      CLS_9000,  3'd0},
        // error status at its top extreme, unlisted status word
        '{8'hC0, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h03, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'hFF, 1'b1, 1'b1, KIND_DONE,    24'hFFFFFF, CLS_OTHER, 3'd1},
        // unknown tag at the start of a response, then the rest is swallowed silently
        '{8'h55, 1'b0, 1'b1, KIND_FAIL,    24'h0,      CLS_9000,  3'd0},
        '{8'hAA, 1'b1, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        // wrong length byte on the final byte
        '{8'h92, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h02, 1'b1, 1'b1, KIND_FAIL,    24'h0,      CLS_9000,  3'd0},
        // status flags held, then the response stops inside the object
        '{8'h96, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h02, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h0F, 1'b1, 1'b1, KIND_FAIL,    24'h0,      CLS_9000,  3'd0},
        // status object twice, the second one wins
        '{8'h96, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h02, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h05, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h96, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h02, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h0A, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        // zero-length data object
        '{8'h97, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        // payload completes on the final byte: payload then completion
        '{8'h97, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'hFF, 1'b1, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        // payload cut short by the final byte: payload then failure
        '{8'h97, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h02, 1'b0, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0},
        '{8'h00, 1'b1, 1'b0, KIND_PAYLOAD, 24'h0,      CLS_9000,  3'd0}
    };

    // ------------------------------------------------------------------
    // random responses
    // ------------------------------------------------------------------
    logic [15:0] status_words [10] = '{
        16'h9000, 16'h6282, 16'h6300, 16'h6301, 16'h6A81,
        16'h6700, 16'h6A80, 16'h6400, 16'h6401, 16'h6F00
    };

    logic [7:0] resp_bytes [$];

    // appends one byte to the response being built
    function automatic void add_byte(input logic [7:0] b);
        resp_bytes.insert(resp_bytes.size(), b);
    endfunction

    // mostly well-formed responses with random content, some corrupted,
    // some cut short, some plain noise
    task automatic make_response();
        int          style;
        int          len;
        int          cut;
        logic [15:0] sw;
        resp_bytes.delete();
        style = $urandom_range(0, 9);
        if (style == 9) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 4))
                0: begin
                    sw = ($urandom_range(0, 1) == 1) ? status_words[$urandom_range(0, 9)]
                                                     : 16'($urandom_range(0, 65535));
                    add_byte(TAG_ERR_STATUS);
                    add_byte(LEN_ERR_STATUS);
                    add_byte(8'($urandom_range(0, 255)));
                    add_byte(sw[15:8]);
                    add_byte(sw[7:0]);
                end
                1: begin
                    add_byte(TAG_FRAMING);
                    add_byte(LEN_FRAMING);
                    add_byte(8'($urandom_range(0, 255)));
                end
                2: begin
                    add_byte(TAG_STATUS);
                    add_byte(LEN_STATUS);
                    add_byte(8'($urandom_range(0, 255)));
                    add_byte(8'($urandom_range(0, 255)));
                end
                3: begin
                    // short payloads mostly, a long one now and then
                    len = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 255)
                                                       : $urandom_range(0, 6);
                    add_byte(TAG_DATA);
                    add_byte(8'(len));
                    repeat (len) add_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    add_byte(TAG_RESULT);
                    add_byte(RESULT_TRAILER);
                end
            endcase
        end
        if (style == 7) begin
            resp_bytes[$urandom_range(0, resp_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (style == 8 && resp_bytes.size() > 1) begin
            cut = $urandom_range(1, resp_bytes.size() - 1);
            while (resp_bytes.size() > cut) void'(resp_bytes.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_result     typed_res;
        int unsigned next_pause;
        int unsigned next_hold;
        next_pause = 300;
        next_hold  = 150;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(directed_rows[i].val, directed_rows[i].lst);
            if (directed_rows[i].typed) begin
                typed_res              = '0;
                typed_res.kind         = directed_rows[i].kind;
                typed_res.error_code   = directed_rows[i].code;
                typed_res.error_class  = directed_rows[i].cls;
                typed_res.objects_seen = directed_rows[i].seen;
                // no status object seen: every flag reads clear
                if (directed_rows[i].kind == KIND_DONE) begin
                    typed_res.crc_ok       = 1'b1;
                    typed_res.collision_ok = 1'b1;
                    typed_res.parity_ok    = 1'b1;
                    typed_res.framing_ok   = 1'b1;
                end
                pending_results[pending_results.size() - 1] = typed_res;
            end
        end

        while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
            make_response();
            for (int k = 0; k < resp_bytes.size(); k++) begin
                send_byte(resp_bytes[k], k == resp_bytes.size() - 1);
            end
            // receiver holds off while we keep offering bytes
            if (items_sent >= next_hold) begin
                hold_req  = 1'b1;
                next_hold = next_hold + 500;
            end
            // now and then let everything drain before carrying on
            if (items_sent >= next_pause) begin
                next_pause = next_pause + 400;
                if (pending_results.size() != 0) begin
                    i_in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // catch anything extra the parser might still emit
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
